### design/ssd_pkg.sv
// shared types and constants of the sample standard deviation unit
// no dependencies; used by ssd_front, ssd_back and the top level
`timescale 1ns / 1ps

package ssd_pkg;

   // fixed port widths
   localparam int SAMPLE_PORT_WIDTH = 16;
   localparam int DEVIATION_WIDTH   = 24;
   localparam int STATUS_WIDTH      = 2;

   // result status codes
   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_SHORT    = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   // back end sequencer
   typedef enum logic [2:0] {
      BACK_IDLE,
      BACK_MUL_SQ,
      BACK_MUL_NS,
      BACK_SUBTRACT,
      BACK_MUL_DEN,
      BACK_DIVIDE,
      BACK_ROOT,
      BACK_DONE
   } back_state_type;

endpackage

### design/ssd_front.sv
// front end: takes samples, squares them and keeps count, sum and sum of squares
// depends on ssd_pkg; hands one job per finished set to the job queue
`timescale 1ns / 1ps

module ssd_front #(
   parameter int MAX_SAMPLES  = 65536,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [ssd_pkg::SAMPLE_PORT_WIDTH-1:0]  req_sample,
   input  logic                                   req_last,
   input  logic                                   req_push,
   output logic                                   req_full,
   input  logic                                   job_full,
   output logic                                   job_push,
   output logic [$clog2(MAX_SAMPLES+1)-1:0]       job_count,
   output logic [SAMPLE_WIDTH+$clog2(MAX_SAMPLES+1)-1:0] job_sum,
   output logic [2*SAMPLE_WIDTH+$clog2(MAX_SAMPLES+1)-2:0] job_sumsq,
   output ssd_pkg::status_type                    job_status
);

   localparam int CW   = $clog2(MAX_SAMPLES + 1);
   localparam int SUMW = SAMPLE_WIDTH + CW;
   localparam int SQW  = 2 * SAMPLE_WIDTH + CW - 1;
   localparam int PRW  = 2 * SAMPLE_WIDTH - 1;

   logic                           advance;
   logic                           update;
   logic                           keep;

   logic                           s1_valid_ff, s1_valid_in;
   logic                           s1_last_ff, s1_last_in;
   logic signed [SAMPLE_WIDTH-1:0] s1_value_ff, s1_value_in;
   logic signed [2*SAMPLE_WIDTH-1:0] product;

   logic                           s2_valid_ff, s2_valid_in;
   logic                           s2_last_ff, s2_last_in;
   logic signed [SAMPLE_WIDTH-1:0] s2_value_ff, s2_value_in;
   logic [PRW-1:0]                 s2_square_ff, s2_square_in;

   logic [CW-1:0]                  count_ff, count_in, count_next;
   logic [SUMW-1:0]                sum_ff, sum_in, sum_next;
   logic [SQW-1:0]                 sumsq_ff, sumsq_in, sumsq_next;
   logic                           overflow_ff, overflow_in, overflow_next;

   // pipeline stalls only when a finished set cannot enter the queue
   always_comb begin
      advance  = !(s2_valid_ff && s2_last_ff && job_full);
      req_full = !advance;
      update   = advance && s2_valid_ff;
   end

   // stage one captures the transaction, stage two holds its square
   always_comb begin
      product      = s1_value_ff * s1_value_ff;
      s1_valid_in  = advance ? req_push : s1_valid_ff;
      s1_last_in   = advance ? req_last : s1_last_ff;
      s1_value_in  = advance ? req_sample[SAMPLE_WIDTH-1:0] : s1_value_ff;
      s2_valid_in  = advance ? s1_valid_ff : s2_valid_ff;
      s2_last_in   = advance ? s1_last_ff : s2_last_ff;
      s2_value_in  = advance ? s1_value_ff : s2_value_ff;
      s2_square_in = advance ? product[PRW-1:0] : s2_square_ff;
   end

   // accumulate, saturating the count
   always_comb begin
      keep          = count_ff < CW'(MAX_SAMPLES);
      count_next    = keep ? count_ff + CW'(1) : count_ff;
      sum_next      = keep ? sum_ff + {{CW{s2_value_ff[SAMPLE_WIDTH-1]}}, s2_value_ff}
                           : sum_ff;
      sumsq_next    = keep ? sumsq_ff + SQW'(s2_square_ff) : sumsq_ff;
      overflow_next = overflow_ff || !keep;

      count_in    = count_ff;
      sum_in      = sum_ff;
      sumsq_in    = sumsq_ff;
      overflow_in = overflow_ff;
      if (update) begin
         if (s2_last_ff) begin
            count_in    = '0;
            sum_in      = '0;
            sumsq_in    = '0;
            overflow_in = 1'b0;
         end else begin
            count_in    = count_next;
            sum_in      = sum_next;
            sumsq_in    = sumsq_next;
            overflow_in = overflow_next;
         end
      end
   end

   // job for the back end, classified here
   always_comb begin
      job_push  = update && s2_last_ff;
      job_count = count_next;
      job_sum   = sum_next;
      job_sumsq = sumsq_next;
      if (count_next < CW'(2)) begin
         job_status = ssd_pkg::STATUS_SHORT;
      end else if (overflow_next) begin
         job_status = ssd_pkg::STATUS_OVERFLOW;
      end else begin
         job_status = ssd_pkg::STATUS_OK;
      end
   end

   // control and accumulator registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         count_ff    <= '0;
         sum_ff      <= '0;
         sumsq_ff    <= '0;
         overflow_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         count_ff    <= count_in;
         sum_ff      <= sum_in;
         sumsq_ff    <= sumsq_in;
         overflow_ff <= overflow_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_last_ff   <= s1_last_in;
      s1_value_ff  <= s1_value_in;
      s2_last_ff   <= s2_last_in;
      s2_value_ff  <= s2_value_in;
      s2_square_ff <= s2_square_in;
   end

endmodule

### design/ssd_queue.sv
// short job queue between the front and back ends
// no dependencies; width and depth come from the instantiating module
`timescale 1ns / 1ps

module ssd_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTRW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTRW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   // pointer and fill count update
   always_comb begin
      full     = count_ff == CNTW'(DEPTH);
      empty    = count_ff == '0;
      do_push  = push && !full;
      do_pop   = pop && !empty;
      pop_data = slot_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTRW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTRW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNTW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### design/ssd_back.sv
// back end: shift-add multiplies, restoring divide and bit-pair square root
// depends on ssd_pkg; takes jobs from ssd_queue and holds the result register
`timescale 1ns / 1ps

module ssd_back #(
   parameter int MAX_SAMPLES  = 65536,
   parameter int SAMPLE_WIDTH = 16,
   parameter int FRAC_BITS    = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   job_empty,
   output logic                                   job_pop,
   input  logic [$clog2(MAX_SAMPLES+1)-1:0]       job_count,
   input  logic [SAMPLE_WIDTH+$clog2(MAX_SAMPLES+1)-1:0] job_sum,
   input  logic [2*SAMPLE_WIDTH+$clog2(MAX_SAMPLES+1)-2:0] job_sumsq,
   input  ssd_pkg::status_type                    job_status,
   output logic [ssd_pkg::DEVIATION_WIDTH-1:0]    rsp_deviation,
   output logic [ssd_pkg::STATUS_WIDTH-1:0]       rsp_status,
   output logic                                   rsp_empty,
   input  logic                                   rsp_pop
);

   localparam int CW   = $clog2(MAX_SAMPLES + 1);
   localparam int SUMW = SAMPLE_WIDTH + CW;
   localparam int SQW  = 2 * SAMPLE_WIDTH + CW - 1;
   localparam int PW   = 2 * SUMW;
   localparam int DENW = 2 * CW;
   localparam int DW   = PW + 2 * FRAC_BITS;
   localparam int QW   = 2 * SAMPLE_WIDTH - 1 + 2 * FRAC_BITS;
   localparam int RW   = (QW + 1) / 2;
   localparam int CNTW = $clog2(DW);

   ssd_pkg::back_state_type state_ff, state_in;

   logic [CNTW-1:0]      cnt_ff, cnt_in;
   logic                 cnt_end_mul, cnt_end_div, cnt_end_root;

   logic [CW-1:0]        count_ff, count_in;
   logic [SQW-1:0]       sumsq_ff, sumsq_in;
   ssd_pkg::status_type  status_ff, status_in;
   logic [SUMW-1:0]      sum_mag;

   logic [PW-1:0]        mcand_ff, mcand_in;
   logic [SUMW-1:0]      mplier_ff, mplier_in;
   logic [PW-1:0]        acc_ff, acc_in, acc_step;
   logic [PW-1:0]        sq_ff, sq_in;

   logic [DENW-1:0]      den_ff, den_in;
   logic [DW-1:0]        dividend_ff, dividend_in;
   logic [DENW-1:0]      rem_ff, rem_in;
   logic [DENW:0]        rem_shift;
   logic [DENW+1:0]      rem_diff;
   logic                 div_ge;
   logic [QW-1:0]        quot_ff, quot_in, quot_step;

   logic [2*RW-1:0]      radicand_ff, radicand_in;
   logic [RW+1:0]        srem_ff, srem_in;
   logic [RW+3:0]        srem_shift;
   logic [RW+4:0]        srem_diff;
   logic                 root_ge;
   logic [RW-1:0]        root_ff, root_in, root_step;

   logic                 out_valid_ff, out_valid_in;
   logic [ssd_pkg::DEVIATION_WIDTH-1:0] out_dev_ff, out_dev_in;
   ssd_pkg::status_type  out_status_ff, out_status_in;

   // datapath steps shared by every state
   always_comb begin
      sum_mag   = job_sum[SUMW-1] ? (~job_sum + SUMW'(1)) : job_sum;
      acc_step  = mplier_ff[0] ? acc_ff + mcand_ff : acc_ff;

      rem_shift = {rem_ff, dividend_ff[DW-1]};
      rem_diff  = {1'b0, rem_shift} - (DENW+2)'(den_ff);
      div_ge    = !rem_diff[DENW+1];
      quot_step = {quot_ff[QW-2:0], div_ge};

      srem_shift = {srem_ff, radicand_ff[2*RW-1 -: 2]};
      srem_diff  = {1'b0, srem_shift} - (RW+5)'({root_ff, 2'b01});
      root_ge    = !srem_diff[RW+4];
      root_step  = {root_ff[RW-2:0], root_ge};

      cnt_end_mul  = cnt_ff == CNTW'(SUMW - 1);
      cnt_end_div  = cnt_ff == CNTW'(DW - 1);
      cnt_end_root = cnt_ff == CNTW'(RW - 1);
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff + CNTW'(1);
      count_in      = count_ff;
      sumsq_in      = sumsq_ff;
      status_in     = status_ff;
      mcand_in      = {mcand_ff[PW-2:0], 1'b0};
      mplier_in     = mplier_ff >> 1;
      acc_in        = acc_step;
      sq_in         = sq_ff;
      den_in        = den_ff;
      dividend_in   = dividend_ff;
      rem_in        = rem_ff;
      quot_in       = quot_ff;
      radicand_in   = radicand_ff;
      srem_in       = srem_ff;
      root_in       = root_ff;
      job_pop       = 1'b0;
      out_valid_in  = out_valid_ff && !rsp_pop;
      out_dev_in    = out_dev_ff;
      out_status_in = out_status_ff;

      case (state_ff)
         ssd_pkg::BACK_IDLE: begin
            cnt_in = '0;
            if (!job_empty) begin
               job_pop   = 1'b1;
               count_in  = job_count;
               sumsq_in  = job_sumsq;
               status_in = job_status;
               mcand_in  = PW'(sum_mag);
               mplier_in = sum_mag;
               acc_in    = '0;
               if (job_status == ssd_pkg::STATUS_SHORT) begin
                  root_in  = '0;
                  state_in = ssd_pkg::BACK_DONE;
               end else begin
                  state_in = ssd_pkg::BACK_MUL_SQ;
               end
            end
         end
         ssd_pkg::BACK_MUL_SQ: begin
            if (cnt_end_mul) begin
               cnt_in    = '0;
               sq_in     = acc_step;
               mcand_in  = PW'(sumsq_ff);
               mplier_in = SUMW'(count_ff);
               acc_in    = '0;
               state_in  = ssd_pkg::BACK_MUL_NS;
            end
         end
         ssd_pkg::BACK_MUL_NS: begin
            if (cnt_end_mul) begin
               cnt_in   = '0;
               state_in = ssd_pkg::BACK_SUBTRACT;
            end
         end
         ssd_pkg::BACK_SUBTRACT: begin
            // numerator n*sum_sq - sum^2, scaled for the fraction bits
            cnt_in      = '0;
            dividend_in = DW'(acc_ff - sq_ff) << (2 * FRAC_BITS);
            mcand_in    = PW'(count_ff);
            mplier_in   = SUMW'(count_ff - CW'(1));
            acc_in      = '0;
            state_in    = ssd_pkg::BACK_MUL_DEN;
         end
         ssd_pkg::BACK_MUL_DEN: begin
            if (cnt_end_mul) begin
               cnt_in   = '0;
               den_in   = acc_step[DENW-1:0];
               rem_in   = '0;
               quot_in  = '0;
               state_in = ssd_pkg::BACK_DIVIDE;
            end
         end
         ssd_pkg::BACK_DIVIDE: begin
            dividend_in = {dividend_ff[DW-2:0], 1'b0};
            rem_in      = div_ge ? rem_diff[DENW-1:0] : rem_shift[DENW-1:0];
            quot_in     = quot_step;
            if (cnt_end_div) begin
               cnt_in      = '0;
               radicand_in = (2*RW)'(quot_step);
               srem_in     = '0;
               root_in     = '0;
               state_in    = ssd_pkg::BACK_ROOT;
            end
         end
         ssd_pkg::BACK_ROOT: begin
            radicand_in = {radicand_ff[2*RW-3:0], 2'b00};
            srem_in     = root_ge ? srem_diff[RW+1:0] : srem_shift[RW+1:0];
            root_in     = root_step;
            if (cnt_end_root) begin
               cnt_in   = '0;
               state_in = ssd_pkg::BACK_DONE;
            end
         end
         ssd_pkg::BACK_DONE: begin
            // wait for the result register to be free
            cnt_in = '0;
            if (!out_valid_ff || rsp_pop) begin
               out_valid_in  = 1'b1;
               out_dev_in    = ssd_pkg::DEVIATION_WIDTH'(root_ff);
               out_status_in = status_ff;
               state_in      = ssd_pkg::BACK_IDLE;
            end
         end
         default: begin
            state_in = ssd_pkg::BACK_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_empty     = !out_valid_ff;
      rsp_deviation = out_dev_ff;
      rsp_status    = out_status_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ssd_pkg::BACK_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      count_ff      <= count_in;
      sumsq_ff      <= sumsq_in;
      status_ff     <= status_in;
      mcand_ff      <= mcand_in;
      mplier_ff     <= mplier_in;
      acc_ff        <= acc_in;
      sq_ff         <= sq_in;
      den_ff        <= den_in;
      dividend_ff   <= dividend_in;
      rem_ff        <= rem_in;
      quot_ff       <= quot_in;
      radicand_ff   <= radicand_in;
      srem_ff       <= srem_in;
      root_ff       <= root_in;
      out_dev_ff    <= out_dev_in;
      out_status_ff <= out_status_in;
   end

endmodule

### design/sample_standard_deviation_unit.sv
// Sample standard deviation unit. Samples are accepted at one per clock cycle
// through a capture stage and a square stage; on the sample flagged last the
// set's count, sum and sum of squares go into a two-entry job queue and the
// accumulators restart, so the next set streams in at once. The back end works
// through one set at a time with its one-bit shift-add multiplier, one-bit
// restoring divider and one-bit-pair square root loop. A set of fewer than two
// samples skips the arithmetic and returns with status one. The input stalls
// only when the job queue is full. Result: floor(sqrt(var) * 2^FRAC_BITS),
// status two when a set ran past MAX_SAMPLES (extra samples dropped).
// depends on ssd_pkg, ssd_front, ssd_queue and ssd_back
`timescale 1ns / 1ps

module sample_standard_deviation_unit #(
   parameter int MAX_SAMPLES  = 65536,
   parameter int SAMPLE_WIDTH = 16,
   parameter int FRAC_BITS    = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [ssd_pkg::SAMPLE_PORT_WIDTH-1:0] req_sample,
   input  logic                                  req_last,
   input  logic                                  req_push,
   output logic                                  req_full,
   output logic [ssd_pkg::DEVIATION_WIDTH-1:0]   rsp_deviation,
   output logic [ssd_pkg::STATUS_WIDTH-1:0]      rsp_status,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop
);

   localparam int CW          = $clog2(MAX_SAMPLES + 1);
   localparam int SUMW        = SAMPLE_WIDTH + CW;
   localparam int SQW         = 2 * SAMPLE_WIDTH + CW - 1;
   localparam int JOBW        = CW + SUMW + SQW + ssd_pkg::STATUS_WIDTH;
   localparam int QUEUE_DEPTH = 2;

   logic                 job_push, job_full, job_pop, job_empty;
   logic [CW-1:0]        front_count, back_count;
   logic [SUMW-1:0]      front_sum, back_sum;
   logic [SQW-1:0]       front_sumsq, back_sumsq;
   ssd_pkg::status_type  front_status, back_status;
   logic [JOBW-1:0]      push_data, pop_data;

   // accumulation front end
   ssd_front #(
      .MAX_SAMPLES  (MAX_SAMPLES),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_sample (req_sample),
      .req_last   (req_last),
      .req_push   (req_push),
      .req_full   (req_full),
      .job_full   (job_full),
      .job_push   (job_push),
      .job_count  (front_count),
      .job_sum    (front_sum),
      .job_sumsq  (front_sumsq),
      .job_status (front_status)
   );

   // job packing across the queue
   always_comb begin
      push_data   = {front_count, front_sum, front_sumsq, front_status};
      back_count  = pop_data[JOBW-1 -: CW];
      back_sum    = pop_data[JOBW-CW-1 -: SUMW];
      back_sumsq  = pop_data[ssd_pkg::STATUS_WIDTH +: SQW];
      back_status = ssd_pkg::status_type'(pop_data[ssd_pkg::STATUS_WIDTH-1:0]);
   end

   ssd_queue #(
      .WIDTH (JOBW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (push_data),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (pop_data),
      .empty     (job_empty)
   );

   // arithmetic back end
   ssd_back #(
      .MAX_SAMPLES  (MAX_SAMPLES),
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .FRAC_BITS    (FRAC_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .job_empty     (job_empty),
      .job_pop       (job_pop),
      .job_count     (back_count),
      .job_sum       (back_sum),
      .job_sumsq     (back_sumsq),
      .job_status    (back_status),
      .rsp_deviation (rsp_deviation),
      .rsp_status    (rsp_status),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop)
   );

endmodule

### sim/tb_sample_standard_deviation_unit.sv
// self-checking testbench of the sample standard deviation unit
// depends on ssd_pkg and sample_standard_deviation_unit, and through it on ssd_front, ssd_queue and ssd_back
`timescale 1ns / 1ps

module tb_sample_standard_deviation_unit;

   localparam int SET_LIMIT  = 65536;
   localparam int FRACTION   = 8;
   localparam int RANDOM_ITEMS = 1150;

   typedef struct {
      logic [ssd_pkg::DEVIATION_WIDTH-1:0] deviation;
      ssd_pkg::status_type                 status;
   } set_result_type;

   logic                                  clock;
   logic                                  reset;
   logic [ssd_pkg::SAMPLE_PORT_WIDTH-1:0] req_sample;
   logic                                  req_last;
   logic                                  req_push;
   logic                                  req_full;
   logic [ssd_pkg::DEVIATION_WIDTH-1:0]   rsp_deviation;
   logic [ssd_pkg::STATUS_WIDTH-1:0]      rsp_status;
   logic                                  rsp_empty;
   logic                                  rsp_pop;

   // accumulators of the set currently streaming in
   logic [16:0]        set_count;
   logic signed [32:0] set_sum;
   logic [47:0]        set_square_sum;
   logic               set_overflow;

   set_result_type pending_results[$];
   set_result_type head_result;
   int             mismatch_count;
   bit             idling_on;
   int             pop_stall_left;

   sample_standard_deviation_unit uut (
      .clock         (clock),
      .reset         (reset),
      .req_sample    (req_sample),
      .req_last      (req_last),
      .req_push      (req_push),
      .req_full      (req_full),
      .rsp_deviation (rsp_deviation),
      .rsp_status    (rsp_status),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop)
   );

   // clock generation
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // integer square root, one result bit at a time from the top
   function automatic logic [ssd_pkg::DEVIATION_WIDTH-1:0] fixed_root(
      input longint unsigned x);
      longint unsigned r;
      longint unsigned trial;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         trial = r | (64'd1 << b);
         if (trial * trial <= x) r = trial;
      end
      return r[ssd_pkg::DEVIATION_WIDTH-1:0];
   endfunction

   // exact sample deviation of the current set, FRACTION bits below the point
   function automatic logic [ssd_pkg::DEVIATION_WIDTH-1:0] set_deviation();
      longint unsigned n, squares, total_mag, numer, denom, quot, remain, scaled;
      longint signed   total;
      n         = set_count;
      squares   = set_square_sum;
      total     = set_sum;
      total_mag = (total < 0) ? -total : total;
      numer     = n * squares - total_mag * total_mag;
      denom     = n * (n - 1);
      quot      = numer / denom;
      remain    = numer % denom;
      scaled    = (quot << (2 * FRACTION)) + ((remain << (2 * FRACTION)) / denom);
      return fixed_root(scaled);
   endfunction

   // fold one accepted sample into the set; a last sample closes the set
   function automatic void fold_sample(input logic [ssd_pkg::SAMPLE_PORT_WIDTH-1:0] value,
                                       input logic is_last);
      longint signed   v;
      longint unsigned mag;
      set_result_type  outcome;
      v   = $signed(value);
      mag = (v < 0) ? -v : v;
      if (set_count < SET_LIMIT) begin
         set_count      = set_count + 17'd1;
         set_sum        = set_sum + $signed(value);
         set_square_sum = set_square_sum + 48'(mag * mag);
      end else begin
         set_overflow = 1'b1;
      end
      if (is_last) begin
         if (set_count < 2) begin
            outcome.deviation = '0;
            outcome.status    = ssd_pkg::STATUS_SHORT;
         end else begin
            outcome.deviation = set_deviation();
            outcome.status    = set_overflow ? ssd_pkg::STATUS_OVERFLOW : ssd_pkg::STATUS_OK;
         end
         pending_results.insert(pending_results.size(), outcome);
         set_count      = '0;
         set_sum        = '0;
         set_square_sum = '0;
         set_overflow   = 1'b0;
      end
   endfunction

   // push one sample, optionally after an idle burst; returns at a falling edge
   task automatic send_sample(input logic [ssd_pkg::SAMPLE_PORT_WIDTH-1:0] value,
                              input logic is_last);
      if (idling_on && $urandom_range(0, 7) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_sample <= value;
      req_last   <= is_last;
      req_push   <= 1'b1;
      do @(posedge clock); while (req_full);
      fold_sample(value, is_last);
      @(negedge clock);
   endtask

   // random sample: full range, near zero, extremes or close to a set centre
   function automatic logic [ssd_pkg::SAMPLE_PORT_WIDTH-1:0] pick_sample(
      input logic [ssd_pkg::SAMPLE_PORT_WIDTH-1:0] centre);
      int kind;
      kind = $urandom_range(0, 19);
      if (kind < 10) return 16'($urandom_range(0, 65535));
      if (kind < 14) return 16'($urandom_range(0, 128) - 64);
      if (kind < 17) begin
         case ($urandom_range(0, 4))
            0: return 16'h8000;
            1: return 16'h8001;
            2: return 16'h7fff;
            3: return 16'hffff;
            default: return 16'h0000;
         endcase
      end
      return centre + 16'($urandom_range(0, 16) - 8);
   endfunction

   // one set of the given length with random content
   task automatic send_random_set(input int length);
      logic [ssd_pkg::SAMPLE_PORT_WIDTH-1:0] centre;
      centre = 16'($urandom_range(0, 65535));
      for (int i = 0; i < length; i++)
         send_sample(pick_sample(centre), i == length - 1);
   endtask

   // sets of one sample give the short status
   task automatic test_short_sets();
      send_sample(16'h0000, 1'b1);
      send_sample(16'h8000, 1'b1);
      send_sample(16'h7fff, 1'b1);
   endtask

   // extreme values, zero spread and the widest spread
   task automatic test_extreme_sets();
      send_sample(16'h8000, 1'b0);
      send_sample(16'h7fff, 1'b1);
      send_sample(16'h7fff, 1'b0);
      send_sample(16'h7fff, 1'b0);
      send_sample(16'h7fff, 1'b1);
      send_sample(16'h8000, 1'b0);
      send_sample(16'h8000, 1'b1);
      for (int i = 0; i < 4; i++)
         send_sample((i % 2 == 0) ? 16'h8000 : 16'h7fff, i == 3);
      send_sample(16'hffff, 1'b0);
      send_sample(16'h0001, 1'b1);
   endtask

   // random sets of mostly modest length
   task automatic test_random_sets();
      int sent;
      int pick;
      int length;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 19);
         if (pick < 2)       length = 1;
         else if (pick < 14) length = $urandom_range(2, 8);
         else if (pick < 19) length = $urandom_range(9, 30);
         else                length = $urandom_range(31, 120);
         send_random_set(length);
         sent += length;
      end
   endtask

   // short sets streamed with no idling so the job queue fills up
   task automatic test_back_to_back();
      idling_on = 1'b0;
      for (int i = 0; i < 40; i++)
         send_random_set($urandom_range(1, 3));
   endtask

   // result side: random pop stalls in short bursts
   always @(negedge clock) begin
      if (pop_stall_left > 0) begin
         pop_stall_left <= pop_stall_left - 1;
         rsp_pop        <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         pop_stall_left <= $urandom_range(0, 2);
         rsp_pop        <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   // compare each popped transaction with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual deviation %0d status %0d",
                     $time, rsp_deviation, rsp_status);
            mismatch_count++;
         end else begin
            head_result = pending_results.pop_front();
            if (rsp_deviation !== head_result.deviation) begin
               $display("%0t: deviation mismatch, expected %0d, actual %0d",
                        $time, head_result.deviation, rsp_deviation);
               mismatch_count++;
            end
            if (rsp_status !== head_result.status) begin
               $display("%0t: status mismatch, expected %0d, actual %0d",
                        $time, head_result.status, rsp_status);
               mismatch_count++;
            end
         end
      end
   end

   // main sequence
   initial begin
      reset          = 1'b1;
      req_sample     = '0;
      req_last       = 1'b0;
      req_push       = 1'b0;
      rsp_pop        = 1'b0;
      pop_stall_left = 0;
      idling_on      = 1'b1;
      mismatch_count = 0;
      set_count      = '0;
      set_sum        = '0;
      set_square_sum = '0;
      set_overflow   = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_short_sets();
      test_extreme_sets();
      test_random_sets();
      test_back_to_back();

      req_push <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // watchdog
   initial begin
      #60_000_000;
      $display("%0t: timeout", $time);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
